FILE: rtl/itt_pkg.sv
package itt_pkg;

  localparam int TextW = 8;
  localparam int RoleW = 4;
  localparam int ErrW  = 3;
  localparam int RowW  = 16;
  localparam int ModeW = 4;

  localparam logic [TextW-1:0] ChNewline = 8'h0A;
  localparam logic [TextW-1:0] ChSemi    = 8'h3B;
  localparam logic [TextW-1:0] ChLbrack  = 8'h5B;
  localparam logic [TextW-1:0] ChRbrack  = 8'h5D;
  localparam logic [TextW-1:0] ChEqual   = 8'h3D;
  localparam logic [TextW-1:0] ChSpace   = 8'h20;
  localparam logic [TextW-1:0] ChUnder   = 8'h5F;

  typedef enum logic [ModeW-1:0] {
    MODE_NEWLINE = 4'd0,
    MODE_SECT    = 4'd1,
    MODE_ENDSECT = 4'd2,
    MODE_VAR     = 4'd3,
    MODE_ENDVAR  = 4'd4,
    MODE_WAITVAL = 4'd5,
    MODE_VAL     = 4'd6,
    MODE_SKIP    = 4'd7,
    MODE_HALT    = 4'd8
  } mode_t;

  typedef enum logic [RoleW-1:0] {
    ROLE_NONE       = 4'd0,
    ROLE_SECT_OPEN  = 4'd1,
    ROLE_SECT_CHAR  = 4'd2,
    ROLE_VAR_START  = 4'd3,
    ROLE_VAR_CHAR   = 4'd4,
    ROLE_VAR_DONE   = 4'd5,
    ROLE_VAL_START  = 4'd6,
    ROLE_VAL_CHAR   = 4'd7,
    ROLE_VAL_DONE   = 4'd8,
    ROLE_ERROR      = 4'd9
  } role_t;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_SECTION = 3'd1,
    ERR_LINE       = 3'd2,
    ERR_SECTION    = 3'd3,
    ERR_VARIABLE   = 3'd4
  } err_t;

  function automatic logic is_alpha(input logic [TextW-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [TextW-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [TextW-1:0] c);
    return c == ChSpace || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_word(input logic [TextW-1:0] c);
    return is_alpha(c) || is_digit(c) || c == ChUnder;
  endfunction

endpackage

FILE: rtl/itt_in_if.sv
interface itt_in_if import itt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TextW-1:0] text_byte;
  logic             start_of_file;

  modport source (output valid, text_byte, start_of_file, input ready);
  modport sink (input valid, text_byte, start_of_file, output ready);
endinterface

FILE: rtl/itt_out_if.sv
interface itt_out_if import itt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RoleW-1:0] role;
  logic [ErrW-1:0]  error_code;
  logic [RowW-1:0]  row_number;
  logic [TextW-1:0] echo_byte;
  logic [ModeW-1:0] mode_after;

  modport source (output valid, role, error_code, row_number, echo_byte, mode_after,
                  input ready);
  modport sink (input valid, role, error_code, row_number, echo_byte, mode_after,
                output ready);
endinterface

FILE: rtl/itt_step.sv
module itt_step import itt_pkg::*; #(
  parameter int ROW_BITS = 16
) (
  input  mode_t               mode,
  input  logic [ROW_BITS-1:0] row,
  input  logic                sect,
  input  logic [TextW-1:0]    c,
  input  logic                sof,
  output mode_t               mode_next,
  output logic [ROW_BITS-1:0] row_next,
  output logic                sect_next,
  output role_t               role,
  output err_t                err
);

  mode_t               m;
  logic [ROW_BITS-1:0] r;
  logic [ROW_BITS-1:0] r_inc;
  logic                bump;

  // start of file resets the context before the byte is handled
  assign m = sof ? MODE_NEWLINE : mode;
  assign r = sof ? ROW_BITS'(1) : row;
  assign r_inc = (&r) ? r : r + ROW_BITS'(1);

  always_comb begin
    mode_next = m;
    sect_next = sof ? 1'b0 : sect;
    role      = ROLE_NONE;
    err       = ERR_NONE;
    bump      = 1'b0;
    case (m)
      MODE_NEWLINE: begin
        if (c == ChNewline) begin
          bump = 1'b1;
        end else if (c == ChSemi) begin
          mode_next = MODE_SKIP;
        end else if (c == ChLbrack) begin
          mode_next = MODE_SECT;
          sect_next = 1'b0;
          role      = ROLE_SECT_OPEN;
        end else if (is_alpha(c)) begin
          if (sect_next) begin
            mode_next = MODE_VAR;
            role      = ROLE_VAR_START;
          end else begin
            err = ERR_NO_SECTION;
          end
        end else if (!is_space(c)) begin
          err = ERR_LINE;
        end
      end
      MODE_SECT: begin
        if (c == ChRbrack) begin
          mode_next = MODE_ENDSECT;
        end else if (is_word(c)) begin
          sect_next = 1'b1;
          role      = ROLE_SECT_CHAR;
        end else begin
          err = ERR_SECTION;
        end
      end
      MODE_ENDSECT: begin
        if (c == ChNewline) begin
          bump      = 1'b1;
          mode_next = MODE_NEWLINE;
        end else if (c == ChSemi) begin
          mode_next = MODE_SKIP;
        end else if (!is_space(c)) begin
          err = ERR_SECTION;
        end
      end
      MODE_VAR: begin
        if (c == ChEqual) begin
          mode_next = MODE_WAITVAL;
          role      = ROLE_VAR_DONE;
        end else if (c == ChSpace) begin
          mode_next = MODE_ENDVAR;
          role      = ROLE_VAR_DONE;
        end else if (is_word(c)) begin
          role = ROLE_VAR_CHAR;
        end else begin
          err = ERR_VARIABLE;
        end
      end
      MODE_ENDVAR: begin
        if (c == ChEqual) begin
          mode_next = MODE_WAITVAL;
        end else if (c != ChSpace) begin
          err = ERR_VARIABLE;
        end
      end
      MODE_WAITVAL: begin
        if (c == ChNewline) begin
          bump      = 1'b1;
          mode_next = MODE_NEWLINE;
        end else if (c == ChSemi) begin
          mode_next = MODE_SKIP;
        end else if (c != ChSpace) begin
          mode_next = MODE_VAL;
          role      = ROLE_VAL_START;
        end
      end
      MODE_VAL: begin
        if (c == ChNewline) begin
          bump      = 1'b1;
          mode_next = MODE_NEWLINE;
          role      = ROLE_VAL_DONE;
        end else if (c == ChSemi) begin
          mode_next = MODE_SKIP;
          role      = ROLE_VAL_DONE;
        end else begin
          role = ROLE_VAL_CHAR;
        end
      end
      MODE_SKIP: begin
        if (c == ChNewline) begin
          bump      = 1'b1;
          mode_next = MODE_NEWLINE;
        end
      end
      default: begin
        mode_next = MODE_HALT;
      end
    endcase
    if (err != ERR_NONE) begin
      role      = ROLE_ERROR;
      mode_next = MODE_HALT;
    end
  end

  assign row_next = bump ? r_inc : r;

endmodule

FILE: rtl/ini_text_tokenizer.sv
// INI text tokenizer: takes one byte of INI text per request and returns one
// result per byte, tagging its role in section, variable and value strings,
// any syntax error, the current row (counted from 1, saturating at
// 2^ROW_BITS-1, low 16 bits shown) and the reading mode after the byte.
// The first error halts parsing until a byte with start_of_file set.
// A byte is accepted every cycle while results are taken. The result passes
// through the input register, then the result register, before it is valid.
// A result held by the receiver stalls the next byte in the input register.
// The mode, row and section flag update in the single decode step between the
// two registers.
module ini_text_tokenizer import itt_pkg::*; #(
  parameter int ROW_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  itt_in_if.sink     in_ch,
  itt_out_if.source  out_ch
);

  // input register
  logic             in_vld;
  logic [TextW-1:0] in_byte;
  logic             in_sof;

  // parsing context
  mode_t               mode;
  logic [ROW_BITS-1:0] row;
  logic                sect;

  mode_t               mode_next;
  logic [ROW_BITS-1:0] row_next;
  logic                sect_next;
  role_t               step_role;
  err_t                step_err;

  // result register
  logic             out_vld;
  role_t            out_role;
  err_t             out_err;
  logic [RowW-1:0]  out_row;
  logic [TextW-1:0] out_byte;
  mode_t            out_mode;

  logic                     advance;
  logic [ROW_BITS+RowW-1:0] row_ext;

  assign advance      = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready  = !in_vld || advance;
  assign row_ext      = {{RowW{1'b0}}, row_next};

  itt_step #(.ROW_BITS(ROW_BITS)) u_step (
    .mode      (mode),
    .row       (row),
    .sect      (sect),
    .c         (in_byte),
    .sof       (in_sof),
    .mode_next (mode_next),
    .row_next  (row_next),
    .sect_next (sect_next),
    .role      (step_role),
    .err       (step_err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_byte <= in_ch.text_byte;
      in_sof  <= in_ch.start_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NEWLINE;
      row  <= ROW_BITS'(1);
      sect <= 1'b0;
    end else if (advance) begin
      mode <= mode_next;
      row  <= row_next;
      sect <= sect_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
    if (advance) begin
      out_role <= step_role;
      out_err  <= step_err;
      out_row  <= row_ext[RowW-1:0];
      out_byte <= in_byte;
      out_mode <= mode_next;
    end
  end

  assign out_ch.valid      = out_vld;
  assign out_ch.role       = out_role;
  assign out_ch.error_code = out_err;
  assign out_ch.row_number = out_row;
  assign out_ch.echo_byte  = out_byte;
  assign out_ch.mode_after = out_mode;

`ifndef SYNTH
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (advance && step_err != ERR_NONE) |=> mode == MODE_HALT)
    else $error("error did not halt parsing");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (advance && mode == MODE_HALT && !in_sof) |=> mode == MODE_HALT)
    else $error("left halt without start of file");

  a_row_nonzero: assert property (@(posedge clk) disable iff (rst)
    row != '0)
    else $error("row count reached zero");

  a_role_err: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> ((out_role == ROLE_ERROR) == (out_err != ERR_NONE)))
    else $error("error role and error code disagree");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && mode == MODE_HALT && !in_sof) |=> out_role == ROLE_NONE)
    else $error("halted parser produced a role");
`endif

endmodule

FILE: test/itt_token_checker.sv
`timescale 1ns / 100ps
module itt_token_checker import itt_pkg::*; #(
  parameter int RowBits = 16
) (
  input  logic clk,
  input  logic rst,
  itt_in_if    in_ch,
  itt_out_if   out_ch,
  output int   mismatches,
  output int   tokens_pending,
  output int   tokens_checked,
  output int   errors_flagged
);

  typedef struct packed {
    role_t            role;
    err_t             err;
    logic [RowW-1:0]  row;
    logic [TextW-1:0] echo;
    mode_t            mode;
  } token_t;

  token_t expected_tokens[$];

  // parser state as the tokenizer should hold it
  mode_t              cur_mode;
  logic [RowBits-1:0] cur_row;
  logic               sect_seen;

  function automatic logic letter(input logic [TextW-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic word_byte(input logic [TextW-1:0] c);
    return letter(c) || (c >= "0" && c <= "9") || c == ChUnder;
  endfunction

  function automatic logic blank(input logic [TextW-1:0] c);
    return c == ChSpace || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void bump_row();
    if (cur_row != '1) cur_row = cur_row + RowBits'(1);
  endfunction

  function automatic token_t tokenize_byte(input logic [TextW-1:0] c, input logic sof);
    token_t t;
    role_t  r;
    err_t   e;
    r = ROLE_NONE;
    e = ERR_NONE;
    if (sof) begin
      cur_mode  = MODE_NEWLINE;
      cur_row   = RowBits'(1);
      sect_seen = 1'b0;
    end
    case (cur_mode)
      MODE_NEWLINE: begin
        if (c == ChNewline) bump_row();
        else if (c == ChSemi) cur_mode = MODE_SKIP;
        else if (c == ChLbrack) begin
          cur_mode  = MODE_SECT;
          sect_seen = 1'b0;
          r         = ROLE_SECT_OPEN;
        end else if (letter(c)) begin
          if (sect_seen) begin
            cur_mode = MODE_VAR;
            r        = ROLE_VAR_START;
          end else e = ERR_NO_SECTION;
        end else if (!blank(c)) e = ERR_LINE;
      end
      MODE_SECT: begin
        if (c == ChRbrack) cur_mode = MODE_ENDSECT;
        else if (word_byte(c)) begin
          sect_seen = 1'b1;
          r         = ROLE_SECT_CHAR;
        end else e = ERR_SECTION;
      end
      MODE_ENDSECT: begin
        if (c == ChNewline) begin
          bump_row();
          cur_mode = MODE_NEWLINE;
        end else if (c == ChSemi) cur_mode = MODE_SKIP;
        else if (!blank(c)) e = ERR_SECTION;
      end
      MODE_VAR: begin
        if (c == ChEqual) begin
          cur_mode = MODE_WAITVAL;
          r        = ROLE_VAR_DONE;
        end else if (c == ChSpace) begin
          cur_mode = MODE_ENDVAR;
          r        = ROLE_VAR_DONE;
        end else if (word_byte(c)) r = ROLE_VAR_CHAR;
        else e = ERR_VARIABLE;
      end
      MODE_ENDVAR: begin
        if (c == ChEqual) cur_mode = MODE_WAITVAL;
        else if (c != ChSpace) e = ERR_VARIABLE;
      end
      MODE_WAITVAL: begin
        if (c == ChNewline) begin
          bump_row();
          cur_mode = MODE_NEWLINE;
        end else if (c == ChSemi) cur_mode = MODE_SKIP;
        else if (c != ChSpace) begin
          cur_mode = MODE_VAL;
          r        = ROLE_VAL_START;
        end
      end
      MODE_VAL: begin
        if (c == ChNewline) begin
          bump_row();
          cur_mode = MODE_NEWLINE;
          r        = ROLE_VAL_DONE;
        end else if (c == ChSemi) begin
          cur_mode = MODE_SKIP;
          r        = ROLE_VAL_DONE;
        end else r = ROLE_VAL_CHAR;
      end
      MODE_SKIP: begin
        if (c == ChNewline) begin
          bump_row();
          cur_mode = MODE_NEWLINE;
        end
      end
      default: cur_mode = MODE_HALT;
    endcase
    if (e != ERR_NONE) begin
      r        = ROLE_ERROR;
      cur_mode = MODE_HALT;
    end
    t.role = r;
    t.err  = e;
    t.row  = RowW'(cur_row);
    t.echo = c;
    t.mode = cur_mode;
    return t;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      cur_mode  = MODE_NEWLINE;
      cur_row   = RowBits'(1);
      sect_seen = 1'b0;
      expected_tokens.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          $display("%0t: unrequested result, expected none, actual role %0d byte %0d",
                   $time, out_ch.role, out_ch.echo_byte);
        end else begin
          want = expected_tokens.pop_front();
          tokens_checked++;
          check_field("role", 32'(want.role), 32'(out_ch.role));
          check_field("error_code", 32'(want.err), 32'(out_ch.error_code));
          check_field("row_number", 32'(want.row), 32'(out_ch.row_number));
          check_field("echo_byte", 32'(want.echo), 32'(out_ch.echo_byte));
          check_field("mode_after", 32'(want.mode), 32'(out_ch.mode_after));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = tokenize_byte(in_ch.text_byte, in_ch.start_of_file);
        if (want.role == ROLE_ERROR) errors_flagged++;
        expected_tokens.push_back(want);
      end
    end
    tokens_pending <= expected_tokens.size();
  end

endmodule

FILE: test/tb_ini_text_tokenizer.sv
`timescale 1ns / 100ps
module tb_ini_text_tokenizer;
  import itt_pkg::*;

  localparam int RowBits   = 16;
  localparam int LongStall = 300;
  localparam logic [TextW-1:0] Blanks[5] = '{ChSpace, 8'h09, 8'h0B, 8'h0C, 8'h0D};

  logic clk = 1'b0;
  logic rst;
  int   mismatches, tokens_pending, tokens_checked, errors_flagged;
  int   items_sent;
  logic no_gaps;
  logic long_stall_ask;
  logic have_section;
  logic restart_next;
  logic [TextW-1:0] line_q[$];

  itt_in_if  in_ch ();
  itt_out_if out_ch ();

  ini_text_tokenizer #(.ROW_BITS(RowBits)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  itt_token_checker #(.RowBits(RowBits)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatches     (mismatches),
    .tokens_pending (tokens_pending),
    .tokens_checked (tokens_checked),
    .errors_flagged (errors_flagged)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [TextW-1:0] letter_char();
    int r = $urandom_range(0, 51);
    return (r < 26) ? TextW'(8'h61 + r) : TextW'(8'h41 + r - 26);
  endfunction

  function automatic logic [TextW-1:0] word_char();
    int r = $urandom_range(0, 62);
    if (r == 62) return ChUnder;
    if (r >= 52) return TextW'(8'h30 + r - 52);
    return letter_char();
  endfunction

  function automatic logic [TextW-1:0] blank_char();
    return Blanks[$urandom_range(0, 4)];
  endfunction

  function automatic logic [TextW-1:0] random_but(input logic [TextW-1:0] a, b);
    logic [TextW-1:0] c;
    do c = TextW'($urandom_range(0, 255)); while (c == a || c == b);
    return c;
  endfunction

  task automatic send_byte(input logic [TextW-1:0] b, input logic sof);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.text_byte     <= b;
    in_ch.start_of_file <= sof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic sof_first);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], sof_first && i == 0);
  endtask

  // pending count is registered, so first wait past the last accept, then poll it
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
  endtask

  task automatic add_comment();
    line_q.push_back(ChSemi);
    repeat ($urandom_range(0, 6)) line_q.push_back(random_but(ChNewline, ChNewline));
  endtask

  task automatic build_section();
    int n;
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    line_q.push_back(ChLbrack);
    repeat (n) line_q.push_back(word_char());
    line_q.push_back(ChRbrack);
    have_section = (n != 0);
  endtask

  task automatic build_assignment();
    line_q.push_back(letter_char());
    repeat ($urandom_range(0, 6)) line_q.push_back(word_char());
    repeat ($urandom_range(0, 2)) line_q.push_back(ChSpace);
    line_q.push_back(ChEqual);
    repeat ($urandom_range(0, 2)) line_q.push_back(ChSpace);
    repeat ($urandom_range(0, 8)) line_q.push_back(random_but(ChNewline, ChSemi));
  endtask

  task automatic random_line();
    int   pick;
    logic sof;
    sof = restart_next || ($urandom_range(0, 39) == 0);
    if (sof) begin
      have_section = 1'b0;
      restart_next = 1'b0;
    end
    line_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 12 || (!have_section && pick < 90)) begin
      repeat ($urandom_range(0, 1)) line_q.push_back(blank_char());
      build_section();
      repeat ($urandom_range(0, 2)) line_q.push_back(blank_char());
      if ($urandom_range(0, 3) == 0) add_comment();
    end else if (pick < 68) begin
      repeat ($urandom_range(0, 1)) line_q.push_back(blank_char());
      build_assignment();
      if ($urandom_range(0, 3) == 0) add_comment();
      if (!have_section) restart_next = 1'b1;
    end else if (pick < 80) begin
      add_comment();
    end else if (pick < 88) begin
      repeat ($urandom_range(0, 3)) line_q.push_back(blank_char());
    end else begin
      // broken line: early line break or a stray byte somewhere past the first byte
      if ($urandom_range(0, 1) == 1) build_section();
      else build_assignment();
      line_q[$urandom_range(1, line_q.size() - 1)] =
        ($urandom_range(0, 2) == 0) ? TextW'($urandom_range(0, 255)) : ChNewline;
      restart_next = 1'b1;
    end
    line_q.push_back(ChNewline);
    no_gaps <= ($urandom_range(0, 5) == 0);
    foreach (line_q[i]) send_byte(line_q[i], sof && i == 0);
  endtask

  // result side
  initial begin
    int gap;
    bit stall_served;
    stall_served = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_stall_ask && !stall_served) begin
        stall_served = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LongStall) @(posedge clk);
      end
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int   random_goal, next_pause;
    logic stall_asked;
    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.text_byte     <= '0;
    in_ch.start_of_file <= 1'b0;
    no_gaps             <= 1'b0;
    long_stall_ask      <= 1'b0;
    items_sent   = 0;
    stall_asked  = 1'b0;
    have_section = 1'b0;
    restart_next = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_text("[a_9] \n", 1'b1);
    send_text("kZ  = ", 1'b0);
    send_byte(8'hFF, 1'b0);      // value starts on a byte above 127
    send_byte(ChSemi, 1'b0);     // value closed by a comment
    send_byte(8'h80, 1'b0);
    send_text("\nx=\n", 1'b0);   // newline while still waiting for a value
    send_text("[]\nz", 1'b0);    // empty section keeps the flag clear
    send_byte(8'h00, 1'b0);      // halted, ignored
    send_byte(8'h00, 1'b1);      // restart; NUL at line start is a line error
    send_text("[\n", 1'b1);      // line break inside a section name
    drain();

    random_goal = items_sent + 1400;
    next_pause  = items_sent + 300;
    while (items_sent < random_goal) begin
      random_line();
      if (!stall_asked && items_sent > 450) begin
        long_stall_ask <= 1'b1;
        stall_asked = 1'b1;
      end
      if (items_sent >= next_pause) begin
        drain();
        next_pause = items_sent + 300;
      end
    end
    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d bytes: directed cases, random INI lines with broken ones, restarts",
             items_sent);
    $display("%0d results compared, %0d syntax errors among them, %0d mismatches",
             tokens_checked, errors_flagged, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("%0t: run timed out waiting on the tokenizer", $time);
    $display("status: fail");
    $finish;
  end

endmodule
